FILE: rtl/chks_pkg.sv
// Package with the sizes, status codes and control types of the chained hash key store.
`default_nettype none
package chks_pkg;
    localparam int unsigned BUCKETS  = 64;
    localparam int unsigned CAPACITY = 256;
    localparam int unsigned BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned LNK_W    = $clog2(CAPACITY + 1);
    localparam logic [LNK_W-1:0] EMPTY_MARK = LNK_W'(CAPACITY);
    localparam int unsigned ENT_W    = 32 + 32 + LNK_W;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_MISS      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    typedef struct packed {
        logic load;
        logic clr_head;
        logic rd_head;
        logic rd_entry;
        logic advance;
        logic wr_new;
        logic wr_prev;
        logic wr_head;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_entry;
        logic walk_ok;
        logic key_eq;
        logic key_lt;
        logic op_find;
        logic full;
    } t_sts;
endpackage
`default_nettype wire

FILE: rtl/chained_hash_key_store_unit.sv
// Top level of the chained hash key store.
// Sequence: a load, a head read, then a read and a check per chain entry passed (at most
// the used count), a link state for an insert that adds an entry, and a done state before o_valid.
// Throughput: one word at a time; busy stays high until the result strobe.
// After reset a clearing pass empties every bucket head while busy is high.
// The receiver cannot stall; each result shows for one cycle on o_valid.
`default_nettype none
module chained_hash_key_store_unit
    import chks_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_handle,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [31:0]      o_found_handle
);
    t_cmd w_cmd_ctrl;
    t_cmd w_cmd;
    t_sts w_sts;

    chks_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_sts(w_sts),
        .o_cmd(w_cmd_ctrl), .busy(busy), .o_valid(o_valid)
    );

    chks_link u_link (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd_ctrl), .o_cmd(w_cmd)
    );

    chks_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_opcode(i_opcode), .i_key(i_key),
        .i_handle(i_handle), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_status(o_status), .o_found_handle(o_found_handle)
    );

`ifndef ASSERT_OFF
    a_valid_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !busy) else $error("load while busy");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_FULL)) else $error("bad status");
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_FOUND) |-> (o_found_handle == '0))
        else $error("handle not zero");
`endif
endmodule
`default_nettype wire

FILE: rtl/chks_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module chks_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/chks_datapath.sv
// Datapath: bucket heads, entry pool memory, walk pointers and result registers.
`default_nettype none
module chks_datapath
    import chks_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_handle,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    output logic [2:0]       o_status,
    output logic [31:0]      o_found_handle
);
    localparam int unsigned HEAD_D = (BUCKETS > 1) ? BUCKETS : 2;
    localparam int unsigned ENT_D  = (CAPACITY > 1) ? CAPACITY : 2;
    localparam int unsigned HA_W   = $clog2(HEAD_D);
    localparam int unsigned EA_W   = $clog2(ENT_D);

    logic              r_op;
    logic [31:0]       r_key;
    logic [31:0]       r_handle;
    logic [LNK_W-1:0]  r_cur;
    logic [LNK_W-1:0]  r_prev;
    logic [LNK_W-1:0]  r_used;
    logic [LNK_W-1:0]  r_steps;
    logic [BKT_W:0]    r_clr;
    logic [2:0]        r_status;
    logic [31:0]       r_res;
    logic              r_cur_from_head;

    logic [HA_W-1:0]   w_bkt;
    logic [LNK_W-1:0]  w_head_rd;
    logic              w_head_we;
    logic [HA_W-1:0]   w_head_wa;
    logic [LNK_W-1:0]  w_head_wd;
    logic [ENT_W-1:0]  w_ent_rd;
    logic              w_ent_we;
    logic [EA_W-1:0]   w_ent_wa;
    logic [ENT_W-1:0]  w_ent_wd;
    logic [31:0]       w_ekey;
    logic [31:0]       w_ehdl;
    logic [LNK_W-1:0]  w_elnk;
    logic [LNK_W-1:0]  w_cur;
    logic              w_link_only;

    assign w_bkt = HA_W'(r_key % BUCKETS);
    assign w_cur = r_cur_from_head ? w_head_rd : r_cur;
    assign {w_ekey, w_ehdl, w_elnk} = w_ent_rd;

    always_comb begin
        w_head_we = 1'b0;
        w_head_wa = w_bkt;
        w_head_wd = EMPTY_MARK;
        if (i_cmd.clr_head) begin
            w_head_we = 1'b1;
            w_head_wa = HA_W'(r_clr);
        end else if (i_cmd.wr_head) begin
            w_head_we = 1'b1;
            w_head_wd = r_used;
        end
    end

    assign w_link_only = i_cmd.wr_prev;
    always_comb begin
        w_ent_we = i_cmd.wr_new | i_cmd.wr_prev;
        if (w_link_only) begin
            w_ent_wa = EA_W'(r_prev);
            w_ent_wd = {w_ekey, w_ehdl, LNK_W'(r_used - 1'b1)};
        end else begin
            w_ent_wa = EA_W'(r_used);
            w_ent_wd = {r_key, r_handle, r_cur};
        end
    end

    chks_ram #(.WIDTH(LNK_W), .DEPTH(HEAD_D)) u_head (
        .i_clk(i_clk), .i_we(w_head_we), .i_waddr(w_head_wa), .i_wdata(w_head_wd),
        .i_raddr(w_bkt), .o_rdata(w_head_rd)
    );

    chks_ram #(.WIDTH(ENT_W), .DEPTH(ENT_D)) u_ent (
        .i_clk(i_clk), .i_we(w_ent_we), .i_waddr(w_ent_wa), .i_wdata(w_ent_wd),
        .i_raddr(i_cmd.wr_new ? EA_W'(r_prev) : EA_W'(w_cur)), .o_rdata(w_ent_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_clr  <= '0;
            r_cur_from_head <= 1'b0;
        end else begin
            if (i_cmd.clr_head) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.wr_new) begin
                r_used <= r_used + 1'b1;
            end
            r_cur_from_head <= i_cmd.rd_head;
        end
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_key    <= i_key;
            r_handle <= i_handle;
            r_prev   <= EMPTY_MARK;
            r_steps  <= '0;
            r_status <= ST_MISS;
            r_res    <= '0;
        end
        if (i_cmd.rd_head) begin
            r_cur <= w_head_rd;
        end
        if (i_cmd.rd_entry && r_cur_from_head) begin
            r_cur <= w_head_rd;
        end
        if (i_cmd.advance) begin
            r_prev  <= w_cur;
            r_cur   <= w_elnk;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.done) begin
            if (r_op == OP_FIND) begin
                if (o_sts.is_entry && o_sts.walk_ok && o_sts.key_eq) begin
                    r_status <= ST_FOUND;
                    r_res    <= w_ehdl;
                end else begin
                    r_status <= ST_MISS;
                end
            end else if (o_sts.is_entry && o_sts.walk_ok && o_sts.key_eq) begin
                r_status <= ST_DUPLICATE;
            end else if (o_sts.full) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_INSERTED;
            end
        end
    end

    always_comb begin
        o_sts.clr_last = (r_clr == (BKT_W+1)'(BUCKETS - 1));
        o_sts.is_entry = (w_cur < LNK_W'(CAPACITY));
        o_sts.walk_ok  = (r_steps < r_used);
        o_sts.key_eq   = (w_ekey == r_key);
        o_sts.key_lt   = (r_key < w_ekey);
        o_sts.op_find  = (r_op == OP_FIND);
        o_sts.full     = (r_used >= LNK_W'(CAPACITY));
    end

    assign o_status       = r_status;
    assign o_found_handle = r_res;
endmodule
`default_nettype wire

FILE: rtl/chks_ctrl.sv
// Controller state machine that sequences the reset clearing pass and the bucket chain walk.
`default_nettype none
module chks_ctrl
    import chks_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      busy,
    output logic      o_valid
);
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HEAD  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_LINK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_head = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd_entry = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.is_entry && i_sts.walk_ok && !i_sts.key_eq &&
                    (i_sts.op_find || !i_sts.key_lt)) begin
                    o_cmd.advance = 1'b1;
                    n_state = S_READ;
                end else begin
                    o_cmd.done = 1'b1;
                    if (!i_sts.op_find && !(i_sts.is_entry && i_sts.walk_ok &&
                        i_sts.key_eq) && !i_sts.full) begin
                        o_cmd.wr_new = 1'b0;
                        n_state = S_LINK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LINK: begin
                o_cmd.wr_new = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_DONE);
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
endmodule
`default_nettype wire

FILE: rtl/chks_link.sv
// Link fixup unit: points the predecessor entry or the bucket head at a new entry.
`default_nettype none
module chks_link
    import chks_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    output t_cmd      o_cmd
);
    logic r_prev_head;
    logic r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_head <= 1'b1;
            r_pend      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev_head <= 1'b1;
            end else if (i_cmd.advance) begin
                r_prev_head <= 1'b0;
            end
            r_pend <= i_cmd.wr_new & ~r_prev_head;
        end
    end

    always_comb begin
        o_cmd = i_cmd;
        o_cmd.wr_head = i_cmd.wr_new & r_prev_head;
        o_cmd.wr_prev = r_pend;
    end
endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the chained hash key store: directed, random and pool-full inserts and finds.
`default_nettype none
module testbench;
    import chks_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] handle;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode = OP_INSERT;
    logic [31:0] i_key = '0;
    logic [31:0] i_handle = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [31:0] o_found_handle;

    logic [LNK_W-1:0] head_tbl [BUCKETS];
    logic [31:0]      key_tbl [CAPACITY];
    logic [31:0]      handle_tbl [CAPACITY];
    logic [LNK_W-1:0] link_tbl [CAPACITY];
    int unsigned      entries_used;

    t_answer     answers_due [$];
    logic [31:0] stored_keys [$];
    int unsigned error_count;
    int unsigned words_sent;
    int unsigned answers_seen;
    int unsigned full_seen;
    int unsigned quiet_cycles;
    bit          no_gaps;

    chained_hash_key_store_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_key(i_key), .i_handle(i_handle),
        .o_valid(o_valid), .o_status(o_status), .o_found_handle(o_found_handle)
    );

    always #6 i_clk = ~i_clk;

    task automatic predict_store(input logic op, input logic [31:0] key,
                                 input logic [31:0] handle, output t_answer ans);
        logic [LNK_W-1:0] cur;
        logic [LNK_W-1:0] prev;
        int unsigned      steps;
        int unsigned      bkt;
        bit               hit;
        bkt = key % BUCKETS;
        cur = head_tbl[bkt];
        prev = EMPTY_MARK;
        steps = 0;
        hit = 1'b0;
        ans = '0;
        while (cur < CAPACITY && steps < entries_used) begin
            if (key_tbl[cur] == key) begin
                hit = 1'b1;
                break;
            end
            if (op == OP_INSERT && key < key_tbl[cur]) break;
            prev = cur;
            cur = link_tbl[cur];
            steps++;
        end
        if (op == OP_FIND) begin
            ans.status = hit ? ST_FOUND : ST_MISS;
            if (hit) ans.handle = handle_tbl[cur];
        end else if (hit) begin
            ans.status = ST_DUPLICATE;
        end else if (entries_used >= CAPACITY) begin
            ans.status = ST_FULL;
        end else begin
            key_tbl[entries_used] = key;
            handle_tbl[entries_used] = handle;
            link_tbl[entries_used] = (cur < CAPACITY) ? cur : EMPTY_MARK;
            if (prev < CAPACITY) link_tbl[prev] = LNK_W'(entries_used);
            else head_tbl[bkt] = LNK_W'(entries_used);
            entries_used++;
            stored_keys.push_back(key);
            ans.status = ST_INSERTED;
        end
    endtask

    task automatic send_word(input logic op, input logic [31:0] key, input logic [31:0] handle);
        t_answer ans;
        if (!no_gaps && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_key <= key;
        i_handle <= handle;
        do @(posedge i_clk); while (busy);
        predict_store(op, key, handle, ans);
        answers_due.push_back(ans);
        words_sent++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected word", {29'd0, o_status}, 32'd0);
            end else begin
                want = answers_due.pop_front();
                if (want.status == ST_FULL) full_seen++;
                if (o_status !== want.status)
                    report_mismatch("status", {29'd0, o_status}, {29'd0, want.status});
                if (o_found_handle !== want.handle)
                    report_mismatch("found handle", o_found_handle, want.handle);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic test_directed;
        send_word(OP_FIND, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 32'h0, 32'h0);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_FIND, 32'h0, 32'h1234_5678);
        send_word(OP_FIND, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_INSERT, 32'h0, 32'hAAAA_5555);
        send_word(OP_INSERT, 32'd197, 32'h5555_AAAA);
        send_word(OP_INSERT, 32'd5, 32'h0000_0005);
        send_word(OP_INSERT, 32'd69, 32'h0000_0045);
        send_word(OP_INSERT, 32'd261, 32'h0000_0105);
        send_word(OP_FIND, 32'd5, 32'h0);
        send_word(OP_FIND, 32'd69, 32'h0);
        send_word(OP_FIND, 32'd197, 32'h0);
        send_word(OP_FIND, 32'd261, 32'h0);
        send_word(OP_FIND, 32'd133, 32'h0);
        send_word(OP_FIND, 32'd325, 32'h0);
        send_word(OP_INSERT, 32'd69, 32'h1);
        send_word(OP_FIND, 32'h8000_0000, 32'h0);
    endtask

    task automatic test_random(input int unsigned count);
        logic [31:0] key;
        for (int unsigned n = 0; n < count; n++) begin
            no_gaps = (n >= 600 && n < 900);
            if ($urandom_range(99) < 50 && stored_keys.size() > 0)
                key = stored_keys[$urandom_range(stored_keys.size() - 1)];
            else if ($urandom_range(1))
                key = $urandom();
            else
                key = {26'($urandom_range(32'h03FF_FFFF)), 6'($urandom_range(7) * 9)};
            if ($urandom_range(99) < 45) send_word(OP_INSERT, key, $urandom());
            else send_word(OP_FIND, key, $urandom());
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_full_pool;
        while (entries_used < CAPACITY) send_word(OP_INSERT, $urandom(), $urandom());
        for (int n = 0; n < 20; n++) begin
            send_word(OP_INSERT, $urandom(), $urandom());
            send_word(OP_INSERT, stored_keys[$urandom_range(CAPACITY - 1)], $urandom());
        end
    endtask

    initial begin
        int unsigned waited;
        for (int b = 0; b < BUCKETS; b++) head_tbl[b] = EMPTY_MARK;
        entries_used = 0;
        error_count = 0;
        words_sent = 0;
        answers_seen = 0;
        full_seen = 0;
        quiet_cycles = 0;
        no_gaps = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1500);
        test_full_pool();
        test_random(300);
        start <= 1'b0;
        waited = 0;
        while (answers_due.size() > 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words, checked %0d answers, %0d of them pool full.",
                 words_sent, answers_seen, full_seen);
        $display("Pool holds %0d of %0d entries.", entries_used, CAPACITY);
        if (error_count == 0 && answers_due.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/chks_pkg.sv
rtl/chks_ram.sv
rtl/chks_datapath.sv
rtl/chks_ctrl.sv
rtl/chks_link.sv
rtl/chained_hash_key_store_unit.sv
sim/testbench.sv
